// ===== sv/dwr_pkg.sv =====
package dwr_pkg;

  localparam int unsigned SIZE      = 2048;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned REM_W     = 12;
  localparam int unsigned RND_W     = 32;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [REM_W-1:0] SIZE_COUNT = REM_W'(SIZE);

  localparam logic CMD_DRAW    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD_PICK,
    ST_RD_LAST,
    ST_WR_PICK,
    ST_WR_LAST,
    ST_DONE
  } dwr_state_e;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic div_step;
    logic rd_pick;
    logic rd_last;
    logic wr_pick;
    logic wr_last;
    logic restart;
    logic empty_res;
    logic out_load;
  } dwr_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_last;
    logic count_zero;
    logic out_busy;
  } dwr_stat_t;

endpackage

// ===== sv/dwr_ctrl.sv =====
module dwr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  dwr_pkg::dwr_stat_t stat_i,
  output dwr_pkg::dwr_cmd_t  cmd_o
);
  import dwr_pkg::*;

  dwr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cmd_i == CMD_RESTART) begin
            cmd_o.restart = 1'b1;
            state_d       = ST_DONE;
          end else if (stat_i.count_zero) begin
            cmd_o.empty_res = 1'b1;
            state_d         = ST_DONE;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_RD_PICK;
        end
      end
      ST_RD_PICK: begin
        cmd_o.rd_pick = 1'b1;
        state_d       = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        cmd_o.rd_last = 1'b1;
        state_d       = ST_WR_PICK;
      end
      ST_WR_PICK: begin
        cmd_o.wr_pick = 1'b1;
        state_d       = ST_WR_LAST;
      end
      ST_WR_LAST: begin
        cmd_o.wr_last = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/dwr_datapath.sv =====
module dwr_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dwr_pkg::dwr_cmd_t           cmd_i,
  output dwr_pkg::dwr_stat_t          stat_o,
  input  logic [dwr_pkg::RND_W-1:0]   random_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        drew_o,
  output logic [dwr_pkg::POS_W-1:0]   drawn_position_o,
  output logic [dwr_pkg::REM_W-1:0]   remaining_o
);
  import dwr_pkg::*;

  logic [POS_W-1:0]     pool_mem [SIZE];

  logic [POS_W-1:0]     clr_cnt_q;
  logic [REM_W-1:0]     count_q, count_d;
  logic [RND_W-1:0]     quo_q, quo_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;
  logic [POS_W-1:0]     rdata_q;
  logic [POS_W-1:0]     tmp_q;
  logic                 stg_drew_q;
  logic [POS_W-1:0]     stg_pos_q;
  logic [REM_W-1:0]     stg_rem_q;
  logic                 out_valid_q;
  logic                 drew_q;
  logic [POS_W-1:0]     pos_q;
  logic [REM_W-1:0]     remo_q;

  logic [REM_W:0]       trial;
  logic                 trial_ge;
  logic [POS_W-1:0]     pick;
  logic [POS_W-1:0]     last;
  logic [REM_W-1:0]     count_dec;
  logic [POS_W-1:0]     mem_addr;
  logic [POS_W-1:0]     mem_wdata;
  logic                 mem_we;
  logic                 mem_re;

  assign trial     = {rem_q, quo_q[RND_W-1]};
  assign trial_ge  = trial >= {1'b0, count_q};
  assign pick      = rem_q[POS_W-1:0];
  assign count_dec = count_q - REM_W'(1);
  assign last      = count_dec[POS_W-1:0];

  always_comb begin
    count_d = count_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    step_d  = step_q;
    if (cmd_i.load) begin
      quo_d  = random_value_i;
      rem_d  = '0;
      step_d = '0;
    end else if (cmd_i.div_step) begin
      quo_d  = {quo_q[RND_W-2:0], 1'b0};
      rem_d  = trial_ge ? REM_W'(trial - {1'b0, count_q}) : trial[REM_W-1:0];
      step_d = step_q + DIV_CNT_W'(1);
    end
    if (cmd_i.restart) begin
      count_d = SIZE_COUNT;
    end else if (cmd_i.wr_last) begin
      count_d = count_dec;
    end
  end

  always_comb begin
    mem_addr  = clr_cnt_q;
    mem_wdata = clr_cnt_q;
    mem_we    = cmd_i.clr_wr;
    mem_re    = 1'b0;
    if (cmd_i.rd_pick) begin
      mem_addr = pick;
      mem_re   = 1'b1;
    end else if (cmd_i.rd_last) begin
      mem_addr = last;
      mem_re   = 1'b1;
    end else if (cmd_i.wr_pick) begin
      mem_addr  = pick;
      mem_wdata = rdata_q;
      mem_we    = 1'b1;
    end else if (cmd_i.wr_last) begin
      mem_addr  = last;
      mem_wdata = tmp_q;
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pool_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= pool_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      count_q     <= SIZE_COUNT;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + POS_W'(1);
      end
      count_q <= count_d;
      step_q  <= step_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.rd_last) begin
      tmp_q <= rdata_q;
    end
    if (cmd_i.restart) begin
      stg_drew_q <= 1'b0;
      stg_pos_q  <= '0;
      stg_rem_q  <= SIZE_COUNT;
    end else if (cmd_i.empty_res) begin
      stg_drew_q <= 1'b0;
      stg_pos_q  <= '0;
      stg_rem_q  <= '0;
    end else if (cmd_i.wr_last) begin
      stg_drew_q <= 1'b1;
      stg_pos_q  <= tmp_q;
      stg_rem_q  <= count_dec;
    end
    if (cmd_i.out_load) begin
      drew_q <= stg_drew_q;
      pos_q  <= stg_pos_q;
      remo_q <= stg_rem_q;
    end
  end

  assign stat_o.clr_done   = (clr_cnt_q == '1);
  assign stat_o.div_last   = (step_q == '1);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign drew_o           = drew_q;
  assign drawn_position_o = pos_q;
  assign remaining_o      = remo_q;

`ifndef NO_ASSERTIONS
  a_rem_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> rem_q < count_q)
    else $error("remainder not below pool count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SIZE_COUNT)
    else $error("pool count above size");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before transaction");

  a_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !drew_q) |-> pos_q == '0)
    else $error("position not zero without draw");
`endif

endmodule

// ===== sv/draw_without_repeat.sv =====
// draw_without_repeat: draw pool positions 0..2047 without repeat.
// Input channel (in_valid_i/in_ready_o): cmd_i selects a draw or a restart;
// random_value_i is reduced modulo the remaining count for a draw.
// Output channel (out_valid_o/out_ready_i): one result per input transaction,
// carrying drew_o, drawn_position_o and remaining_o.
// A draw runs from accept through the bit-serial remainder unit, then steps on
// the single-port pool memory (read pick, read last, write pick, write last),
// then loads the result into the output register, where it becomes valid.
// Restart, or a draw on an empty pool, goes straight to loading its result.
// After reset the pool memory is filled with entry i = i in a clearing pass;
// no input is accepted during that pass.
// The result sits in an output register, so the next input transaction is
// accepted while it waits. If the receiver stalls, a finished item holds in
// the final state until the output register is free.
module draw_without_repeat (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic [dwr_pkg::RND_W-1:0] random_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      drew_o,
  output logic [dwr_pkg::POS_W-1:0] drawn_position_o,
  output logic [dwr_pkg::REM_W-1:0] remaining_o
);
  import dwr_pkg::*;

  dwr_cmd_t  cmd;
  dwr_stat_t stat;

  dwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dwr_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .random_value_i   (random_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drew_o           (drew_o),
    .drawn_position_o (drawn_position_o),
    .remaining_o      (remaining_o)
  );

endmodule
